// ----- hdl/ptd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared codes, constants and the half-step coil table for the pan/tilt drive.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int LimitBits  = 12;
  localparam int ReqBits    = 2;
  localparam int CoilBits   = 4;
  localparam int PhaseBits  = 3;
  localparam int InBits     = 8;   // 2 + 2, padded to a byte
  localparam int OutBits    = 16;  // 4 + 4 + 3, padded to two bytes

  localparam logic [LimitBits-1:0] PanLimitReset  = 12'd800;
  localparam logic [LimitBits-1:0] TiltLimitReset = 12'd500;
  localparam int PanPositionReset  = 400;
  localparam int TiltPositionReset = 250;

  localparam logic [CoilBits-1:0]  HoldCoils = 4'b0011;
  localparam logic [PhaseBits-1:0] LastPhase = 3'd7;

  // request codes; the other two codes mean hold
  localparam logic [ReqBits-1:0] REQ_INC = 2'd1;
  localparam logic [ReqBits-1:0] REQ_DEC = 2'd2;

  // configuration register indexes
  localparam logic REG_PAN_LIMIT  = 1'b0;
  localparam logic REG_TILT_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } dir_t;

  // plain-order half-step table, bit n = coil n
  function automatic logic [CoilBits-1:0] half_step(input logic [PhaseBits-1:0] phase);
    logic [CoilBits-1:0] w;
    case (phase)
      3'd0:    w = 4'h3;
      3'd1:    w = 4'h2;
      3'd2:    w = 4'h6;
      3'd3:    w = 4'h4;
      3'd4:    w = 4'hC;
      3'd5:    w = 4'h8;
      3'd6:    w = 4'h9;
      default: w = 4'h1;
    endcase
    return w;
  endfunction

  // increment runs the table in mirrored coil order, decrement in plain order
  function automatic logic [CoilBits-1:0] coil_word(input dir_t dir,
                                                    input logic [PhaseBits-1:0] phase);
    logic [CoilBits-1:0] w;
    logic [CoilBits-1:0] r;
    w = half_step(phase);
    r = {w[0], w[1], w[2], w[3]};
    case (dir)
      DIR_INC: return r;
      DIR_DEC: return w;
      default: return HoldCoils;
    endcase
  endfunction

endpackage

// ----- hdl/pan_tilt_half_step_drive_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_half_step_drive_unit
// Two-axis four-coil stepper half-step sequencer with soft position limits.
// ----------------------------------------------------------------------------
//
//  channel | dir | width | beat contents
//  --------+-----+-------+------------------------------------------------------
//  s_*     | in  | 8     | one command: pan_request, tilt_request
//  m_*     | out | 16+1  | one phase word: pan_coils, tilt_coils, phase_index;
//          |     |       | tlast = last_phase
//  cfg_*   | in  | 12    | limit register writes, index 0 pan, 1 tilt
//
// Each command yields eight output beats, one per cycle while m_tready is high;
// the output phase counter steps through them. A command is taken as soon as
// the one-deep pending slot is free, also while the previous command is still
// streaming out, and goes from s_tvalid to m_tvalid in the next cycle when the
// block is idle. Positions move at the beat that takes the command. Synchronous
// reset restores limits 800/500 and positions 400/250 (masked to POSITION_BITS).
// Output stalls hold the current phase word; input stalls cost nothing.
//
module pan_tilt_half_step_drive_unit #(
  parameter int POSITION_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  // [1:0] pan_request, [3:2] tilt_request, [7:4] zero
  input  logic [ptd_pkg::InBits-1:0]      s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] pan_coils, [7:4] tilt_coils, [10:8] phase_index, [15:11] zero
  output logic [ptd_pkg::OutBits-1:0]     m_tdata,
  output logic                            m_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [ptd_pkg::LimitBits-1:0]   cfg_data
);
  import ptd_pkg::*;

  // compare width: wide enough for both position and limit
  localparam int CmpBits = (POSITION_BITS > LimitBits) ? POSITION_BITS : LimitBits;
  localparam logic [POSITION_BITS-1:0] PanPosInit  = POSITION_BITS'(PanPositionReset);
  localparam logic [POSITION_BITS-1:0] TiltPosInit = POSITION_BITS'(TiltPositionReset);

  logic [LimitBits-1:0]     pan_limit, tilt_limit;
  logic [POSITION_BITS-1:0] pan_position, tilt_position;
  logic [POSITION_BITS-1:0] pan_position_next, tilt_position_next;

  // pending slot: one decided command waiting for the output stage
  logic pend_valid;
  dir_t pend_pan_dir, pend_tilt_dir;

  // output stage: command being streamed and its phase counter
  logic                 out_valid;
  dir_t                 out_pan_dir, out_tilt_dir;
  logic [PhaseBits-1:0] phase;

  logic in_fire, out_fire, out_done;
  dir_t pan_dir_new, tilt_dir_new;

  // decide one axis' move from its request, position and limit
  function automatic dir_t decide(input logic [ReqBits-1:0] req,
                                  input logic [POSITION_BITS-1:0] pos,
                                  input logic [LimitBits-1:0] limit);
    logic below_limit;
    logic at_top;
    below_limit = CmpBits'(pos) < CmpBits'(limit);
    at_top      = &pos;
    if (req == REQ_INC && below_limit && !at_top) begin
      return DIR_INC;
    end else if (req == REQ_DEC && pos != '0) begin
      return DIR_DEC;
    end
    return DIR_HOLD;
  endfunction

  assign s_tready = !pend_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_valid && m_tready;
  // output stage free for a new command at the next edge
  assign out_done = !out_valid || (out_fire && phase == LastPhase);

  assign pan_dir_new  = decide(s_tdata[1:0], pan_position, pan_limit);
  assign tilt_dir_new = decide(s_tdata[3:2], tilt_position, tilt_limit);

  always_comb begin
    pan_position_next  = pan_position;
    tilt_position_next = tilt_position;
    if (pan_dir_new == DIR_INC)  pan_position_next  = pan_position + 1'b1;
    if (pan_dir_new == DIR_DEC)  pan_position_next  = pan_position - 1'b1;
    if (tilt_dir_new == DIR_INC) tilt_position_next = tilt_position + 1'b1;
    if (tilt_dir_new == DIR_DEC) tilt_position_next = tilt_position - 1'b1;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_limit  <= PanLimitReset;
      tilt_limit <= TiltLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAN_LIMIT:  pan_limit  <= cfg_data;
        REG_TILT_LIMIT: tilt_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // positions move when the command is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_position  <= PanPosInit;
      tilt_position <= TiltPosInit;
    end else if (in_fire) begin
      pan_position  <= pan_position_next;
      tilt_position <= tilt_position_next;
    end
  end

  // pending slot and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      phase      <= '0;
    end else begin
      if (out_done) begin
        phase <= '0;
        if (pend_valid) begin
          out_valid    <= 1'b1;
          out_pan_dir  <= pend_pan_dir;
          out_tilt_dir <= pend_tilt_dir;
          pend_valid   <= 1'b0;
        end else if (in_fire) begin
          out_valid    <= 1'b1;
          out_pan_dir  <= pan_dir_new;
          out_tilt_dir <= tilt_dir_new;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (out_fire) begin
        phase <= phase + 1'b1;
      end
      // new command parks in the slot unless it went straight to the output
      if (in_fire && !(out_done && !pend_valid)) begin
        pend_valid    <= 1'b1;
        pend_pan_dir  <= pan_dir_new;
        pend_tilt_dir <= tilt_dir_new;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = (phase == LastPhase);
  assign m_tdata  = {5'b0, phase, coil_word(out_tilt_dir, phase),
                     coil_word(out_pan_dir, phase)};

  // phase counter steps by one on each mid-command beat
  assert property (@(posedge clk) disable iff (rst)
    out_fire && phase != LastPhase |=> out_valid && phase == $past(phase) + 1'b1)
    else $error("phase did not advance");

  // a waiting command follows the last beat with no gap
  assert property (@(posedge clk) disable iff (rst)
    out_fire && phase == LastPhase && pend_valid |=> out_valid && phase == '0)
    else $error("pending command not started");

  // a taken command always shows up on the output side
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("command accepted but no output pending");

  // the slot is never overwritten while full
  assert property (@(posedge clk) disable iff (rst)
    pend_valid && !out_done |=> pend_valid && $stable(pend_pan_dir) &&
                                $stable(pend_tilt_dir))
    else $error("pending slot lost");

endmodule

// ----- tb/pan_tilt_half_step_drive_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_half_step_drive_unit_tb
// Self-checking bench for the two-axis half-step drive. Commands go in on the
// s_ stream and each one is predicted as eight phase words, which are checked
// in order against the m_ stream. Both stream sides idle at random. The limit
// registers are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module pan_tilt_half_step_drive_unit_tb;
  import ptd_pkg::*;

  localparam int POS_BITS    = 12;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [POS_BITS-1:0] POS_TOP = {POS_BITS{1'b1}};

  // the two request codes that mean hold
  localparam logic [ReqBits-1:0] REQ_HOLD    = 2'd0;
  localparam logic [ReqBits-1:0] REQ_HOLD_HI = 2'd3;

  // plain coil order, bit n = coil n
  localparam logic [CoilBits-1:0] STEP_TABLE [8] = '{
    4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9, 4'h1
  };

  typedef struct {
    logic [CoilBits-1:0]  pan_coils;
    logic [CoilBits-1:0]  tilt_coils;
    logic [PhaseBits-1:0] phase;
    logic                 last;
  } phase_word_t;

  logic                 clk;
  logic                 rst;
  logic [InBits-1:0]    s_tdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [OutBits-1:0]   m_tdata;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [LimitBits-1:0] cfg_data;

  pan_tilt_half_step_drive_unit #(
    .POSITION_BITS(POS_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow of the block's state
  logic [LimitBits-1:0] pan_limit_q;
  logic [LimitBits-1:0] tilt_limit_q;
  logic [POS_BITS-1:0]  pan_pos;
  logic [POS_BITS-1:0]  tilt_pos;

  phase_word_t expected_words[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          sink_stall     = 0;
  bit          steady         = 1'b0;  // no gaps on either side while set

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d phase words outstanding", $realtime,
               expected_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // direction actually taken by one axis; the caller moves the position
  function automatic dir_t axis_move(input logic [ReqBits-1:0]   req,
                                     input logic [LimitBits-1:0] limit,
                                     input logic [POS_BITS-1:0]  pos);
    if (req == REQ_INC && pos < limit && pos < POS_TOP) return DIR_INC;
    if (req == REQ_DEC && pos != '0) return DIR_DEC;
    return DIR_HOLD;
  endfunction

  function automatic logic [CoilBits-1:0] drive_pattern(input dir_t d, input int phase);
    logic [CoilBits-1:0] w;
    logic [CoilBits-1:0] m;
    w = STEP_TABLE[phase];
    for (int b = 0; b < CoilBits; b++) m[b] = w[CoilBits-1-b];
    case (d)
      DIR_INC: return m;       // mirrored coil order
      DIR_DEC: return w;
      default: return 4'b0011; // coils 0 and 1 energized
    endcase
  endfunction

  // called at the beat that takes the command
  task automatic predict_command(input logic [ReqBits-1:0] pan_req,
                                 input logic [ReqBits-1:0] tilt_req);
    dir_t        pan_dir;
    dir_t        tilt_dir;
    phase_word_t w;
    pan_dir  = axis_move(pan_req, pan_limit_q, pan_pos);
    tilt_dir = axis_move(tilt_req, tilt_limit_q, tilt_pos);
    if (pan_dir == DIR_INC) pan_pos = pan_pos + 1'b1;
    if (pan_dir == DIR_DEC) pan_pos = pan_pos - 1'b1;
    if (tilt_dir == DIR_INC) tilt_pos = tilt_pos + 1'b1;
    if (tilt_dir == DIR_DEC) tilt_pos = tilt_pos - 1'b1;
    for (int i = 0; i < 8; i++) begin
      w.pan_coils  = drive_pattern(pan_dir, i);
      w.tilt_coils = drive_pattern(tilt_dir, i);
      w.phase      = PhaseBits'(i);
      w.last       = (i == 7);
      expected_words.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      m_tready   <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady && $urandom_range(0, 5) == 0)
        sink_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    phase_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected beat, expected none got %h last %b", $realtime,
                 m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("pan_coils", w.pan_coils, m_tdata[3:0]);
        check_field("tilt_coils", w.tilt_coils, m_tdata[7:4]);
        check_field("phase_index", w.phase, m_tdata[10:8]);
        check_field("last_phase", w.last, m_tlast);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // entered and left right after a rising edge
  task automatic send_command(input logic [ReqBits-1:0] pan_req,
                              input logic [ReqBits-1:0] tilt_req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= InBits'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(InBits-2*ReqBits){1'b0}}, tilt_req, pan_req};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_command(pan_req, tilt_req);
  endtask

  // hold off until every phase word is out, then a few spare cycles
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [LimitBits-1:0] value);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PAN_LIMIT) pan_limit_q = value;
    else tilt_limit_q = value;
  endtask

  function automatic logic [ReqBits-1:0] any_request();
    return ReqBits'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every pan/tilt request pair, both hold codes included
  task automatic test_request_codes();
    for (int p = 0; p < 4; p++)
      for (int t = 0; t < 4; t++)
        send_command(ReqBits'(p), ReqBits'(t));
  endtask

  // pan gets one step of headroom, tilt none
  task automatic test_increment_at_limit();
    write_limit(REG_PAN_LIMIT, pan_pos + 1'b1);
    write_limit(REG_TILT_LIMIT, tilt_pos);
    send_command(REQ_INC, REQ_INC);
    send_command(REQ_INC, REQ_INC);
    send_command(REQ_INC, REQ_HOLD_HI);
    send_command(REQ_DEC, REQ_DEC);
  endtask

  // both positions end up above the limit: up is refused, down still taken
  task automatic test_lowered_limit();
    write_limit(REG_PAN_LIMIT, '0);
    write_limit(REG_TILT_LIMIT, 12'd100);
    send_command(REQ_INC, REQ_INC);
    send_command(REQ_DEC, REQ_DEC);
    send_command(REQ_HOLD_HI, REQ_HOLD);
  endtask

  // tilt driven mostly downward until it sits on zero for a while;
  // pan runs under the widest limit
  task automatic test_sweep_to_zero();
    int n;
    int at_zero;
    logic [ReqBits-1:0] t;
    n       = 0;
    at_zero = 0;
    write_limit(REG_PAN_LIMIT, '1);
    write_limit(REG_TILT_LIMIT, '0);
    while (n < 330 && at_zero < 25) begin
      t = ($urandom_range(0, 99) < 93) ? REQ_DEC : any_request();
      if (tilt_pos == '0) at_zero++;
      send_command(any_request(), t);
      if ($urandom_range(0, 39) == 0) settle_idle();
      n++;
    end
  endtask

  // both axes hover near their limits, the first stretch back to back
  task automatic test_hover_near_limits();
    int r;
    logic [ReqBits-1:0] p;
    write_limit(REG_PAN_LIMIT, pan_pos + 2'd2);
    write_limit(REG_TILT_LIMIT, 12'd3);
    steady = 1'b1;
    for (int n = 0; n < 110; n++) begin
      if (n == 40) steady = 1'b0;
      r = $urandom_range(0, 99);
      p = (r < 45) ? REQ_INC : (r < 70) ? REQ_DEC : any_request();
      send_command(p, any_request());
      if (n > 40 && $urandom_range(0, 39) == 0) settle_idle();
    end
  endtask

  task automatic test_reset_limits();
    write_limit(REG_PAN_LIMIT, PanLimitReset);
    write_limit(REG_TILT_LIMIT, TiltLimitReset);
    for (int n = 0; n < 60; n++) send_command(any_request(), any_request());
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PAN_LIMIT;
    cfg_data  <= '0;
    pan_limit_q  = PanLimitReset;
    tilt_limit_q = TiltLimitReset;
    pan_pos      = POS_BITS'(PanPositionReset);
    tilt_pos     = POS_BITS'(TiltPositionReset);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_request_codes();
    test_increment_at_limit();
    test_lowered_limit();
    test_sweep_to_zero();
    test_hover_near_limits();
    test_reset_limits();

    // drain, then leave room for any stray beat
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ptd_pkg.sv
hdl/pan_tilt_half_step_drive_unit.sv
tb/pan_tilt_half_step_drive_unit_tb.sv
